[rtl/assert_macros.svh]
// Assertion helpers for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion lbl failed");

// Concurrent assertion on the default clock and reset names.
`define ASSERT_PROP(lbl, prop) \
    `ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

[rtl/ps2md_pkg.sv]
package ps2md_pkg;

    // Input kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_STOP = 1'b1;

    // Controller status and packet bit positions
    localparam int STATUS_FULL_BIT = 0;
    localparam int STATUS_AUX_BIT  = 5;
    localparam int RESYNC_BIT      = 3;
    localparam int OVF_X_BIT       = 6;
    localparam int OVF_Y_BIT       = 7;
    localparam int BTN_L_BIT       = 0;
    localparam int BTN_R_BIT       = 1;
    localparam int BTN_M_BIT       = 2;
    localparam int BTN_W           = 3;

    // Event types and codes
    typedef enum logic [1:0] {
        EVT_MOTION = 2'd0,
        EVT_KEY    = 2'd1,
        EVT_SYNC   = 2'd2
    } t_evt_type;

    localparam logic [2:0] CODE_X      = 3'd0;
    localparam logic [2:0] CODE_Y      = 3'd1;
    localparam logic [2:0] CODE_LEFT   = 3'd2;
    localparam logic [2:0] CODE_RIGHT  = 3'd3;
    localparam logic [2:0] CODE_MIDDLE = 3'd4;
    localparam logic [2:0] CODE_NONE   = 3'd0;

    localparam int VALUE_W = 9;

    // One decoded sample handed from front to back
    typedef struct packed {
        logic signed [VALUE_W-1:0] dx;
        logic signed [VALUE_W-1:0] dy;
        logic [BTN_W-1:0]          buttons;
        logic [BTN_W-1:0]          changed;
    } t_job;

    // Job queue sizing
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

[rtl/ps2md_front.sv]
module ps2md_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_accept,
    input  logic              i_kind,
    input  logic [7:0]        i_status,
    input  logic [7:0]        i_data,
    output logic              o_push,
    output ps2md_pkg::t_job   o_job
);

    logic [1:0]                      r_pos, n_pos;
    logic [ps2md_pkg::BTN_W-1:0]     r_held, n_held;
    logic                            r_enable;
    logic [7:0]                      r_b0, r_b1;
    logic                            byte_ok;
    logic [ps2md_pkg::BTN_W-1:0]     pkt_btn;
    logic [ps2md_pkg::BTN_W-1:0]     pkt_chg;
    logic signed [ps2md_pkg::VALUE_W-1:0] pkt_dx, pkt_dy;

    assign byte_ok = i_status[ps2md_pkg::STATUS_FULL_BIT]
                   & i_status[ps2md_pkg::STATUS_AUX_BIT] & r_enable;

    // Decode of a completed packet (third byte is the current data)
    assign pkt_btn = r_b0[ps2md_pkg::BTN_W-1:0];
    assign pkt_chg = pkt_btn ^ r_held;
    assign pkt_dx  = {r_b1[7], r_b1};
    assign pkt_dy  = -{i_data[7], i_data};

    // Packet assembly and held-button tracking
    always_comb begin
        n_pos  = r_pos;
        n_held = r_held;
        o_push = 1'b0;
        o_job  = '{dx: '0, dy: '0, buttons: '0, changed: r_held};
        if (i_accept) begin
            if (i_kind == ps2md_pkg::KIND_STOP) begin
                n_pos = 2'd0;
                if (r_held != '0) begin
                    o_push = 1'b1;
                    n_held = '0;
                end
            end else if (byte_ok) begin
                priority if (r_pos == 2'd0) begin
                    if (i_data[ps2md_pkg::RESYNC_BIT])
                        n_pos = 2'd1;
                end else if (r_pos == 2'd1) begin
                    n_pos = 2'd2;
                end else begin
                    n_pos = 2'd0;
                    o_job = '{dx: pkt_dx, dy: pkt_dy, buttons: pkt_btn, changed: pkt_chg};
                    if (!r_b0[ps2md_pkg::OVF_X_BIT] && !r_b0[ps2md_pkg::OVF_Y_BIT]
                        && (pkt_dx != '0 || pkt_dy != '0 || pkt_chg != '0)) begin
                        o_push = 1'b1;
                        n_held = pkt_btn;
                    end
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 2'd0;
            r_held   <= '0;
            r_enable <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_held <= n_held;
            if (i_cfg_we)
                r_enable <= i_cfg_wdata;
        end
    end

    // Packet byte storage
    always_ff @(posedge i_clk) begin
        if (i_accept && i_kind == ps2md_pkg::KIND_BYTE && byte_ok) begin
            if (r_pos == 2'd0)
                r_b0 <= i_data;
            if (r_pos == 2'd1)
                r_b1 <= i_data;
        end
    end

endmodule

[rtl/ps2md_queue.sv]
module ps2md_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ps2md_pkg::t_job   i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output ps2md_pkg::t_job   o_job
);

    localparam logic [ps2md_pkg::QPTR_W-1:0] PTR_LAST =
        ps2md_pkg::QPTR_W'(ps2md_pkg::QUEUE_DEPTH - 1);
    localparam logic [ps2md_pkg::QCNT_W-1:0] CNT_FULL =
        ps2md_pkg::QCNT_W'(ps2md_pkg::QUEUE_DEPTH);

    ps2md_pkg::t_job                  r_entry [ps2md_pkg::QUEUE_DEPTH];
    logic [ps2md_pkg::QPTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [ps2md_pkg::QCNT_W-1:0]     r_count;
    logic                             do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = r_entry[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push)
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            if (do_pop)
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            if (do_push && !do_pop)
                r_count <= r_count + 1'b1;
            else if (do_pop && !do_push)
                r_count <= r_count - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push)
            r_entry[r_wr_ptr] <= i_job;
    end

endmodule

[rtl/ps2md_back.sv]
module ps2md_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  ps2md_pkg::t_job      i_job,
    output logic                 o_job_pop,
    input  logic                 i_ready,
    output logic                 o_valid,
    output ps2md_pkg::t_evt_type o_type,
    output logic [2:0]           o_code,
    output logic [ps2md_pkg::VALUE_W-1:0] o_value,
    output logic                 o_last
);

    // Pending-event mask bit positions, in emit order
    localparam int PEND_X    = 0;
    localparam int PEND_Y    = 1;
    localparam int PEND_L    = 2;
    localparam int PEND_R    = 3;
    localparam int PEND_M    = 4;
    localparam int PEND_SYNC = 5;
    localparam int PEND_W    = 6;

    logic [PEND_W-1:0]                r_pend, n_pend;
    ps2md_pkg::t_job                  r_job;
    logic                             r_out_valid;
    ps2md_pkg::t_evt_type             r_out_type, n_out_type;
    logic [2:0]                       r_out_code, n_out_code;
    logic [ps2md_pkg::VALUE_W-1:0]    r_out_value, n_out_value;
    logic                             r_out_last, n_out_last;
    logic                             advance;

    assign advance   = (r_pend != '0) && (!r_out_valid || i_ready);
    assign o_job_pop = (r_pend == '0) && i_job_valid;

    // Pick the next pending event
    always_comb begin
        n_pend      = r_pend;
        n_out_type  = ps2md_pkg::EVT_SYNC;
        n_out_code  = ps2md_pkg::CODE_NONE;
        n_out_value = '0;
        n_out_last  = 1'b0;
        priority if (r_pend[PEND_X]) begin
            n_pend[PEND_X] = 1'b0;
            n_out_type     = ps2md_pkg::EVT_MOTION;
            n_out_code     = ps2md_pkg::CODE_X;
            n_out_value    = r_job.dx;
        end else if (r_pend[PEND_Y]) begin
            n_pend[PEND_Y] = 1'b0;
            n_out_type     = ps2md_pkg::EVT_MOTION;
            n_out_code     = ps2md_pkg::CODE_Y;
            n_out_value    = r_job.dy;
        end else if (r_pend[PEND_L]) begin
            n_pend[PEND_L] = 1'b0;
            n_out_type     = ps2md_pkg::EVT_KEY;
            n_out_code     = ps2md_pkg::CODE_LEFT;
            n_out_value    = ps2md_pkg::VALUE_W'(r_job.buttons[ps2md_pkg::BTN_L_BIT]);
        end else if (r_pend[PEND_R]) begin
            n_pend[PEND_R] = 1'b0;
            n_out_type     = ps2md_pkg::EVT_KEY;
            n_out_code     = ps2md_pkg::CODE_RIGHT;
            n_out_value    = ps2md_pkg::VALUE_W'(r_job.buttons[ps2md_pkg::BTN_R_BIT]);
        end else if (r_pend[PEND_M]) begin
            n_pend[PEND_M] = 1'b0;
            n_out_type     = ps2md_pkg::EVT_KEY;
            n_out_code     = ps2md_pkg::CODE_MIDDLE;
            n_out_value    = ps2md_pkg::VALUE_W'(r_job.buttons[ps2md_pkg::BTN_M_BIT]);
        end else begin
            n_pend[PEND_SYNC] = 1'b0;
            n_out_last        = 1'b1;
        end
    end

    // Job load and event mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (o_job_pop) begin
            r_pend <= {1'b1, i_job.changed[ps2md_pkg::BTN_M_BIT],
                       i_job.changed[ps2md_pkg::BTN_R_BIT],
                       i_job.changed[ps2md_pkg::BTN_L_BIT],
                       i_job.dy != '0, i_job.dx != '0};
        end else if (advance) begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop)
            r_job <= i_job;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_type  <= n_out_type;
            r_out_code  <= n_out_code;
            r_out_value <= n_out_value;
            r_out_last  <= n_out_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_type  = r_out_type;
    assign o_code  = r_out_code;
    assign o_value = r_out_value;
    assign o_last  = r_out_last;

endmodule

[rtl/ps2_mouse_packet_event_decoder.sv]
// A packet's or stop beat's first event passes the job queue, event mask and output register.
// Throughput: input beats are taken every cycle while the 2-entry job queue has room;
// the event serializer loads one job at a time and emits its events in order (up to 6),
// taking the next job only once all have left, and stalls the output register on backpressure.
// Reset (i_rst_n low, synchronous): assembly restarts, no buttons held,
// streaming disabled, job queue and output empty.
module ps2_mouse_packet_event_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,      // stream_enable
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,     // [7:0] status_byte, [15:8] data_byte
    input  logic        s_axis_tuser,     // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,     // [2:0] event_code, [11:3] event_value, [15:12] 0
    output logic [1:0]  m_axis_tuser,     // [1:0] event_type
    output logic        m_axis_tlast      // last_event
);

    logic                             accept;
    logic                             push;
    ps2md_pkg::t_job                  front_job;
    logic                             q_full;
    logic                             q_valid;
    ps2md_pkg::t_job                  q_job;
    logic                             pop;
    ps2md_pkg::t_evt_type             ev_type;
    logic [2:0]                       ev_code;
    logic [ps2md_pkg::VALUE_W-1:0]    ev_value;

    assign s_axis_tready = ~q_full;
    assign accept        = s_axis_tvalid & s_axis_tready;

    ps2md_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_kind      (s_axis_tuser),
        .i_status    (s_axis_tdata[7:0]),
        .i_data      (s_axis_tdata[15:8]),
        .o_push      (push),
        .o_job       (front_job)
    );

    ps2md_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    ps2md_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (pop),
        .i_ready     (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_type      (ev_type),
        .o_code      (ev_code),
        .o_value     (ev_value),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tuser = ev_type;
    assign m_axis_tdata = {4'b0000, ev_value, ev_code};

endmodule

[rtl/ps2md_checker.sv]
`include "assert_macros.svh"

module ps2md_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // Only the sync event closes a run
    `ASSERT_PROP(a_last_is_sync, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == ps2md_pkg::EVT_SYNC)

    // Sync carries zero code and value and is always last
    `ASSERT_PROP(a_sync_form, m_axis_tvalid && m_axis_tuser == ps2md_pkg::EVT_SYNC |-> m_axis_tlast && m_axis_tdata == 16'd0)

    // Key events carry a 0/1 state
    `ASSERT_PROP(a_key_value, m_axis_tvalid && m_axis_tuser == ps2md_pkg::EVT_KEY |-> m_axis_tdata[15:4] == 12'd0)

    // A stalled beat holds
    `ASSERT_PROP(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind ps2_mouse_packet_event_decoder ps2md_checker u_ps2md_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[sim/tb_ps2_mouse_packet_event_decoder.sv]
// One expected or observed mouse event
typedef struct packed {
    ps2md_pkg::t_evt_type                 etype;
    logic [2:0]                           code;
    logic signed [ps2md_pkg::VALUE_W-1:0] value;
    logic                                 last;
} t_mouse_event;

// Packet assembler and event predictor plus the in-order event check
class mouse_event_scoreboard;
    bit                        stream_en;
    bit [1:0]                  byte_pos;
    bit [7:0]                  pkt_bytes [3];
    bit [ps2md_pkg::BTN_W-1:0] held_btns;
    t_mouse_event              expected_q [$];
    int                        errors;

    function void set_stream_enable(bit en);
        stream_en = en;
    endfunction

    function void push_event(ps2md_pkg::t_evt_type et, logic [2:0] code,
                             logic signed [ps2md_pkg::VALUE_W-1:0] value, logic last);
        t_mouse_event ev;
        ev.etype = et;
        ev.code  = code;
        ev.value = value;
        ev.last  = last;
        expected_q.push_back(ev);
    endfunction

    // Motion first, then key changes in left/right/middle order, then sync
    function void queue_sample(int dx, int dy, bit [ps2md_pkg::BTN_W-1:0] btns,
                               bit [ps2md_pkg::BTN_W-1:0] chg);
        if (dx != 0)
            push_event(ps2md_pkg::EVT_MOTION, ps2md_pkg::CODE_X,
                       ps2md_pkg::VALUE_W'(dx), 1'b0);
        if (dy != 0)
            push_event(ps2md_pkg::EVT_MOTION, ps2md_pkg::CODE_Y,
                       ps2md_pkg::VALUE_W'(dy), 1'b0);
        if (chg[ps2md_pkg::BTN_L_BIT])
            push_event(ps2md_pkg::EVT_KEY, ps2md_pkg::CODE_LEFT,
                       ps2md_pkg::VALUE_W'(btns[ps2md_pkg::BTN_L_BIT]), 1'b0);
        if (chg[ps2md_pkg::BTN_R_BIT])
            push_event(ps2md_pkg::EVT_KEY, ps2md_pkg::CODE_RIGHT,
                       ps2md_pkg::VALUE_W'(btns[ps2md_pkg::BTN_R_BIT]), 1'b0);
        if (chg[ps2md_pkg::BTN_M_BIT])
            push_event(ps2md_pkg::EVT_KEY, ps2md_pkg::CODE_MIDDLE,
                       ps2md_pkg::VALUE_W'(btns[ps2md_pkg::BTN_M_BIT]), 1'b0);
        push_event(ps2md_pkg::EVT_SYNC, ps2md_pkg::CODE_NONE, '0, 1'b1);
    endfunction

    // Called once per accepted input beat
    function void note_beat(logic kind, bit [7:0] status, bit [7:0] data);
        bit [ps2md_pkg::BTN_W-1:0] btns;
        bit [ps2md_pkg::BTN_W-1:0] chg;
        int                        dx;
        int                        dy;
        if (kind == ps2md_pkg::KIND_STOP) begin
            byte_pos = 0;
            if (held_btns != 0) begin
                chg = held_btns;
                held_btns = 0;
                queue_sample(0, 0, '0, chg);
            end
            return;
        end
        if (!(status[ps2md_pkg::STATUS_FULL_BIT] && status[ps2md_pkg::STATUS_AUX_BIT]))
            return;
        if (!stream_en) return;
        // first byte must carry the sync bit, otherwise skip it
        if (byte_pos == 0 && !data[ps2md_pkg::RESYNC_BIT]) return;
        pkt_bytes[byte_pos] = data;
        byte_pos++;
        if (byte_pos != 3) return;
        byte_pos = 0;
        if (pkt_bytes[0][ps2md_pkg::OVF_X_BIT] || pkt_bytes[0][ps2md_pkg::OVF_Y_BIT]) return;
        dx   = $signed(pkt_bytes[1]);
        dy   = -$signed(pkt_bytes[2]);
        btns = pkt_bytes[0][ps2md_pkg::BTN_W-1:0];
        chg  = btns ^ held_btns;
        if (dx == 0 && dy == 0 && chg == 0) return;
        held_btns = btns;
        queue_sample(dx, dy, btns, chg);
    endfunction

    // Called once per accepted output beat
    function void check_event(logic [1:0] et, logic [2:0] code,
                              logic signed [ps2md_pkg::VALUE_W-1:0] value, logic last);
        t_mouse_event ev;
        if (expected_q.size() == 0) begin
            $error("unexpected event: event_type %0d event_code %0d event_value %0d",
                   et, code, value);
            errors++;
            return;
        end
        ev = expected_q.pop_front();
        if (ev.etype !== et) begin
            $error("event_type: expected %0d, actual %0d", ev.etype, et);
            errors++;
        end
        if (ev.code !== code) begin
            $error("event_code: expected %0d, actual %0d", ev.code, code);
            errors++;
        end
        if (ev.value !== value) begin
            $error("event_value: expected %0d, actual %0d", ev.value, value);
            errors++;
        end
        if (ev.last !== last) begin
            $error("last_event: expected %0d, actual %0d", ev.last, last);
            errors++;
        end
    endfunction
endclass

module tb_ps2_mouse_packet_event_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] ST_FULL     = 8'(1 << ps2md_pkg::STATUS_FULL_BIT);
    localparam logic [7:0] ST_AUX      = 8'(1 << ps2md_pkg::STATUS_AUX_BIT);
    localparam logic [7:0] ST_VALID    = ST_FULL | ST_AUX;
    localparam int         RANDOM_ITEMS = 110;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         RX_HOLD_CYCLES = 400;
    localparam int         STALL_LIMIT = 3000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    mouse_event_scoreboard sb = new;

    bit tx_idle_en  = 1'b1;
    bit rx_idle_en  = 1'b1;
    bit rx_hold_req = 1'b0;
    int stall_cnt   = 0;

    ps2_mouse_packet_event_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Offer one beat, with random gaps ahead of it while tx_idle_en is set, and wait for the handshake
    task automatic send_beat(logic kind, logic [7:0] status, logic [7:0] data);
        if (tx_idle_en) begin
            while ($urandom_range(0, 99) < 30) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {data, status};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_beat(kind, status, data);
    endtask

    // Stop offering, let every expected event come out, then settle
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_stream_enable(logic en);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= en;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_stream_enable(en);
    endtask

    // Zero, the byte extremes, small deltas and random bytes mixed
    function automatic logic [7:0] rand_delta();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'h80;
            2: return 8'h7f;
            3: return 8'hff;
            4, 5, 6: return 8'($signed($urandom_range(0, 15)) - 8);
            default: return 8'($urandom);
        endcase
    endfunction

    // Receiver: random backpressure or always ready, or one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                m_axis_tready <= rx_idle_en ? ($urandom_range(0, 99) >= 30) : 1'b1;
            end
        end
    end

    // Output check
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_event(m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[11:3], m_axis_tlast);
    end

    // Watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("tb_ps2_mouse_packet_event_decoder: done, errors");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // Stimulus
    initial begin
        int         n_items;
        int         pick;
        bit         hold_done;
        bit         tx_back;
        bit         calm_done;
        bit         off_done;
        logic [7:0] st;
        logic [7:0] first;
        logic [7:0] pkt [3];

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ps2md_pkg::KIND_BYTE;
        n_items       = 0;
        hold_done     = 1'b0;
        tx_back       = 1'b0;
        calm_done     = 1'b0;
        off_done      = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // streaming still off after reset: byte ignored, stop with nothing held
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h09);
        send_beat(ps2md_pkg::KIND_STOP, 8'h00, 8'h00);
        write_stream_enable(1'b1);

        // all buttons pressed, X max, Y from 0x80 gives +128: six events
        send_beat(ps2md_pkg::KIND_BYTE, 8'hff, 8'h0f);
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h7f);
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h80);
        // all released, X min, Y -127
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h08);
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h80);
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h7f);
        // no motion, no button change: silent
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h08);
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h00);
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h00);
        // first bytes without the sync bit are skipped
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h00);
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'hf7);
        // packet with bytes lacking full or aux status in between
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h09);
        send_beat(ps2md_pkg::KIND_BYTE, ST_AUX, 8'h55);
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h01);
        send_beat(ps2md_pkg::KIND_BYTE, ST_FULL, 8'h33);
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'hff);
        // X overflow, then Y overflow: both dropped
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h48);
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h05);
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h05);
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h89);
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h05);
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h05);
        // stop in the middle of a packet releases left
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h0a);
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h03);
        send_beat(ps2md_pkg::KIND_STOP, 8'hff, 8'hff);
        // right and middle pressed, then released by a stop
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h0e);
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h00);
        send_beat(ps2md_pkg::KIND_BYTE, ST_VALID, 8'h00);
        send_beat(ps2md_pkg::KIND_STOP, 8'h00, 8'h00);

        // random traffic, mostly well-formed packets
        while (n_items < RANDOM_ITEMS) begin
            if (n_items >= 25 && !hold_done) begin
                hold_done   = 1'b1;
                tx_idle_en  = 1'b0;
                rx_hold_req = 1'b1;
            end
            if (n_items >= 40 && !tx_back) begin
                tx_back    = 1'b1;
                tx_idle_en = 1'b1;
            end
            if (n_items >= 55 && !calm_done) begin
                calm_done  = 1'b1;
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            if (n_items >= 80 && !off_done) begin
                off_done   = 1'b1;
                tx_idle_en = 1'b1;
                rx_idle_en = 1'b1;
                // streaming off: bytes ignored, stops still release
                write_stream_enable(1'b0);
                repeat (12) begin
                    send_beat($urandom_range(0, 7) == 0 ? ps2md_pkg::KIND_STOP
                                                        : ps2md_pkg::KIND_BYTE,
                              8'($urandom) | ST_VALID, 8'($urandom));
                end
                write_stream_enable(1'b1);
            end

            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_beat(ps2md_pkg::KIND_STOP, 8'($urandom), 8'($urandom));
                n_items++;
            end else if (pick < 10) begin
                send_beat(ps2md_pkg::KIND_BYTE, 8'($urandom) | ST_VALID, 8'($urandom));
                n_items++;
            end else begin
                first = 8'($urandom);
                first[ps2md_pkg::RESYNC_BIT] = 1'b1;
                first[ps2md_pkg::OVF_X_BIT]  = ($urandom_range(0, 9) == 0);
                first[ps2md_pkg::OVF_Y_BIT]  = ($urandom_range(0, 9) == 0);
                pkt[0] = first;
                pkt[1] = rand_delta();
                pkt[2] = rand_delta();
                for (int b = 0; b < 3; b++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        st = 8'($urandom);
                        if ($urandom_range(0, 1) == 0) st[ps2md_pkg::STATUS_FULL_BIT] = 1'b0;
                        else st[ps2md_pkg::STATUS_AUX_BIT] = 1'b0;
                        send_beat(ps2md_pkg::KIND_BYTE, st, 8'($urandom));
                    end
                    send_beat(ps2md_pkg::KIND_BYTE, 8'($urandom) | ST_VALID, pkt[b]);
                    n_items++;
                end
            end
        end

        drain();
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb_ps2_mouse_packet_event_decoder: done, clean");
        else
            $display("tb_ps2_mouse_packet_event_decoder: done, errors");
        $finish;
    end
endmodule
